[src/tms_pkg.sv]
// Shared types and constants for the transform matrix stack.
package tms_pkg;

   typedef enum logic [2:0] {
      ACT_IDENTITY = 3'd0,
      ACT_WRITE    = 3'd1,
      ACT_LOAD     = 3'd2,
      ACT_MULTIPLY = 3'd3,
      ACT_PUSH     = 3'd4,
      ACT_POP      = 3'd5,
      ACT_READ     = 3'd6,
      ACT_NONE     = 3'd7
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_BOTTOM    = 2'd2,
      STAT_SATURATED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_MUL_READ,
      ST_MUL_WAIT,
      ST_MUL_WRITE,
      ST_WB,
      ST_READ_WAIT,
      ST_DONE
   } state_type;

   localparam int ELEMS = 16;
   localparam int ELEM_IDX_BITS = 4;
   localparam int IN_WIDTH = 32;
   localparam int DEPTH_OUT_BITS = 6;

endpackage

[src/tms_dot.sv]
// Four-term fixed-point dot product with floor shift, registered products, saturation.
module tms_dot import tms_pkg::*; #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic signed [ELEM_WIDTH-1:0] a_in [4],
   input  logic signed [ELEM_WIDTH-1:0] b_in [4],
   output logic signed [ELEM_WIDTH-1:0] dot_out,
   output logic                         sat_out
);
   localparam int PW = 2 * ELEM_WIDTH;
   localparam int SW = PW + 2;

   logic signed [PW-1:0] prod_ff [4];
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] emax;
   logic signed [SW-1:0] emin;

   // register the four products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         prod_ff[k] <= PW'(a_in[k]) * PW'(b_in[k]);
      end
   end

   // add shifted products and clamp
   always_comb begin
      sum = '0;
      for (int k = 0; k < 4; k++) begin
         sum = sum + (SW'(prod_ff[k]) >>> FRAC_BITS);
      end
      emax = SW'({1'b0, {(ELEM_WIDTH-1){1'b1}}});
      emin = -emax - SW'(1);
      sat_out = 1'b0;
      if (sum > emax) begin
         dot_out = emax[ELEM_WIDTH-1:0];
         sat_out = 1'b1;
      end else if (sum < emin) begin
         dot_out = emin[ELEM_WIDTH-1:0];
         sat_out = 1'b1;
      end else begin
         dot_out = sum[ELEM_WIDTH-1:0];
      end
   end

endmodule

[src/transform_matrix_stack.sv]
// Top level of the transform matrix stack.
// Usage: raise start with req_action, req_elem_index and req_elem_value while busy
// is low; the request is taken at that edge and busy rises. Exactly one response
// follows, shown for one cycle with rsp_valid: rsp_read_value, rsp_status and
// rsp_stack_depth. The receiver cannot stall; the response is simply dropped on
// the ports for that one cycle.
// Sequence from the accepting edge to the response: write, pop, a refused push and
// the unused action go straight to the done state; read waits for the memory read;
// identity and load write the level (one element written per cycle); push reads
// each element, then writes it to the next level; multiply, for each of 16
// elements, reads four top elements, each with a read and a wait state, then the
// four-multiplier dot unit registers the products and the result is captured, and
// a write-back of all 16 results follows. busy drops in the response cycle, so a new
// request can be taken there; none is taken while one is in progress.
// All levels live in one level memory of STACK_DEPTH*16 words with one read and
// one write port and registered read data.
// Reset: a sweep writes the identity into level zero, busy high, then the stack
// holds one matrix and the operand registers are cleared.
module transform_matrix_stack import tms_pkg::*; #(
   parameter int STACK_DEPTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int ELEM_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_action,
   input  logic [ELEM_IDX_BITS-1:0]  req_elem_index,
   input  logic signed [IN_WIDTH-1:0] req_elem_value,
   output logic                      rsp_valid,
   output logic signed [IN_WIDTH-1:0] rsp_read_value,
   output logic [1:0]                rsp_status,
   output logic [DEPTH_OUT_BITS-1:0] rsp_stack_depth
);
   localparam int LB = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int AW = LB + ELEM_IDX_BITS;
   localparam int MEM_WORDS = STACK_DEPTH * ELEMS;

   logic signed [ELEM_WIDTH-1:0] mem [MEM_WORDS];
   logic signed [ELEM_WIDTH-1:0] opnd_ff [ELEMS];
   logic signed [ELEM_WIDTH-1:0] rdata_ff;
   logic signed [ELEM_WIDTH-1:0] row_ff [4];
   logic signed [ELEM_WIDTH-1:0] res_ff [ELEMS];

   state_type state_ff, state_in;
   action_type act_ff, act_in;
   logic [LB-1:0] top_ff, top_in;
   logic [ELEM_IDX_BITS-1:0] cnt_ff, cnt_in;
   logic [1:0] sub_ff, sub_in;
   logic sat_ff, sat_in;
   logic [1:0] stat_ff, stat_in;
   logic signed [IN_WIDTH-1:0] rval_ff, rval_in;
   logic valid_ff, valid_in;
   logic phase_ff, phase_in;

   logic we;
   logic [AW-1:0] waddr, raddr;
   logic signed [ELEM_WIDTH-1:0] wdata;
   logic signed [ELEM_WIDTH-1:0] one_val, dot;
   logic dot_sat;
   logic signed [ELEM_WIDTH-1:0] a_vec [4];
   logic signed [ELEM_WIDTH-1:0] b_vec [4];
   logic signed [ELEM_WIDTH-1:0] val_ext;
   logic [LB:0] top_next;

   // identity one, clamped to the element range
   always_comb begin
      if (FRAC_BITS >= ELEM_WIDTH - 1) begin
         one_val = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
      end else begin
         one_val = ELEM_WIDTH'(1) << FRAC_BITS;
      end
   end

   assign val_ext = ELEM_WIDTH'($signed(req_elem_value));
   assign top_next = {1'b0, top_ff} + (LB+1)'(1);

   // level memory, one read and one write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   tms_dot #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dot (
      .clock   (clock),
      .a_in    (a_vec),
      .b_in    (b_vec),
      .dot_out (dot),
      .sat_out (dot_sat)
   );

   // column of the operand for the element in progress
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_vec[k] = row_ff[k];
         b_vec[k] = opnd_ff[{cnt_ff[3:2], 2'(k)}];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         top_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         top_ff   <= top_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      sub_ff   <= sub_in;
      sat_ff   <= sat_in;
      stat_ff  <= stat_in;
      rval_ff  <= rval_in;
      phase_ff <= phase_in;
      if (reset) begin
         for (int i = 0; i < ELEMS; i++) opnd_ff[i] <= '0;
      end else if (start && !busy && action_type'(req_action) == ACT_WRITE) begin
         opnd_ff[req_elem_index] <= val_ext;
      end
      if (state_ff == ST_MUL_WAIT && phase_ff) begin
         row_ff[sub_ff] <= rdata_ff;
      end
      if (state_ff == ST_MUL_WRITE && phase_ff) begin
         res_ff[cnt_ff] <= dot;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      top_in   = top_ff;
      cnt_in   = cnt_ff;
      sub_in   = sub_ff;
      sat_in   = sat_ff;
      stat_in  = stat_ff;
      rval_in  = rval_ff;
      phase_in = phase_ff;
      valid_in = 1'b0;
      we       = 1'b0;
      waddr    = {top_ff, cnt_ff};
      raddr    = {top_ff, cnt_ff};
      wdata    = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_SWEEP: begin
            we     = 1'b1;
            waddr  = {LB'(0), cnt_ff};
            wdata  = (cnt_ff[1:0] == cnt_ff[3:2]) ? one_val : '0;
            cnt_in = cnt_ff + ELEM_IDX_BITS'(1);
            if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               act_in   = action_type'(req_action);
               cnt_in   = '0;
               sub_in   = '0;
               sat_in   = 1'b0;
               stat_in  = STAT_OK;
               rval_in  = '0;
               phase_in = 1'b0;
               state_in = ST_DONE;
               unique case (action_type'(req_action))
                  ACT_IDENTITY, ACT_LOAD, ACT_MULTIPLY: state_in = ST_MUL_READ;
                  ACT_READ: begin
                     raddr    = {top_ff, req_elem_index};
                     state_in = ST_READ_WAIT;
                  end
                  ACT_PUSH: begin
                     if (top_next < (LB+1)'(STACK_DEPTH)) begin
                        state_in = ST_MUL_READ;
                     end else begin
                        stat_in = STAT_FULL;
                     end
                  end
                  ACT_POP: begin
                     if (top_ff != '0) top_in = top_ff - LB'(1);
                     else stat_in = STAT_BOTTOM;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ_WAIT: begin
            rval_in  = IN_WIDTH'(rdata_ff);
            state_in = ST_DONE;
         end
         ST_MUL_READ: begin
            // identity and load write directly; push and multiply read first
            unique case (act_ff)
               ACT_IDENTITY: begin
                  we     = 1'b1;
                  wdata  = (cnt_ff[1:0] == cnt_ff[3:2]) ? one_val : '0;
                  cnt_in = cnt_ff + ELEM_IDX_BITS'(1);
                  if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) state_in = ST_DONE;
               end
               ACT_LOAD: begin
                  we     = 1'b1;
                  wdata  = opnd_ff[cnt_ff];
                  cnt_in = cnt_ff + ELEM_IDX_BITS'(1);
                  if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) state_in = ST_DONE;
               end
               ACT_PUSH: begin
                  raddr    = {top_ff, cnt_ff};
                  state_in = ST_MUL_WAIT;
               end
               default: begin
                  // fetch top[k*4+row] for row = cnt[1:0]
                  raddr    = {top_ff, sub_ff, cnt_ff[1:0]};
                  phase_in = 1'b1;
                  state_in = ST_MUL_WAIT;
               end
            endcase
         end
         ST_MUL_WAIT: begin
            if (act_ff == ACT_PUSH) begin
               we    = 1'b1;
               waddr = {top_next[LB-1:0], cnt_ff};
               wdata = rdata_ff;
               cnt_in = cnt_ff + ELEM_IDX_BITS'(1);
               if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) begin
                  top_in   = top_next[LB-1:0];
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL_READ;
               end
            end else begin
               phase_in = 1'b0;
               sub_in   = sub_ff + 2'(1);
               if (sub_ff == 2'd3) state_in = ST_MUL_WRITE;
               else state_in = ST_MUL_READ;
            end
         end
         ST_MUL_WRITE: begin
            // product settles in the cycle after the row is complete
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               sat_in   = sat_ff | dot_sat;
               cnt_in   = cnt_ff + ELEM_IDX_BITS'(1);
               if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) begin
                  cnt_in   = '0;
                  act_in   = ACT_LOAD;
                  state_in = ST_WB;
               end else begin
                  state_in = ST_MUL_READ;
               end
            end
         end
         ST_WB: begin
            we     = 1'b1;
            wdata  = res_ff[cnt_ff];
            cnt_in = cnt_ff + ELEM_IDX_BITS'(1);
            if (cnt_ff == ELEM_IDX_BITS'(ELEMS-1)) begin
               if (sat_ff) stat_in = STAT_SATURATED;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response outputs
   assign rsp_valid       = valid_ff;
   assign rsp_read_value  = rval_ff;
   assign rsp_status      = stat_ff;
   assign rsp_stack_depth = DEPTH_OUT_BITS'({1'b0, top_ff} + (LB+1)'(1));

endmodule
